FILE: sv/beacon_payload_chunk_framer_assert.svh
// Assertion macros shared by the framer's top level.
`ifndef BEACON_PAYLOAD_CHUNK_FRAMER_ASSERT_SVH
`define BEACON_PAYLOAD_CHUNK_FRAMER_ASSERT_SVH

// Check a condition at every clock edge out of reset
`define BPCF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define BPCF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/bpcf_pkg.sv
// Shared types, constants and the beacon header table of the chunk framer.
package bpcf_pkg;

  localparam int HDR_BYTES = 36;
  localparam int PH_W      = 6;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_CHUNK = 2'd0;
  localparam logic [1:0] CFG_REPL_CHAR = 2'd1;
  localparam logic [1:0] CFG_CHUNK_TAG = 2'd2;

  // Printable ASCII bounds
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  typedef struct packed {
    logic [7:0] max_chunk;
    logic [7:0] repl_char;
    logic [7:0] chunk_tag;
  } cfg_t;

  // One classified payload word for the emitter
  typedef struct packed {
    logic       hdr;        // emit the beacon header first
    logic       open;       // emit tag and chunk length first
    logic [7:0] clen;
    logic [7:0] tag;
    logic [7:0] data;       // payload byte after replacement
    logic       last;       // final payload byte of the message
  } cmd_t;

  function automatic logic [7:0] hdr_byte(input logic [PH_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      6'd0:  b = 8'h80;
      6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9: b = 8'hff;
      6'd10, 6'd14, 6'd16, 6'd20: b = 8'hde;
      6'd11, 6'd15, 6'd17, 6'd21: b = 8'had;
      6'd12, 6'd18: b = 8'hbe;
      6'd13, 6'd19: b = 8'hef;
      6'd32: b = 8'h64;
      6'd34: b = 8'h11;
      6'd35: b = 8'h04;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/beacon_payload_chunk_framer.sv
// Top level of the beacon payload chunk framer: config registers, front, queue, back.
//
//   channel   dir  fields (lowest bit up)
//   s_axis    in   tdata: payload_byte[7:0], message_length[18:8], zero pad [23:19]
//   m_axis    out  tdata: frame_byte[7:0]; tuser: run_last; tlast: frame_end
//   cfg       in   cfg_we, cfg_index (0 max_chunk, 1 replacement_char, 2 chunk_tag),
//                  cfg_data
//
// One frame byte leaves per cycle through the output register while m_tready is high
// and commands are queued. A payload word yields its payload byte, plus tag and chunk
// length bytes when it opens a chunk, plus 36 header bytes when it opens a message
// (up to 39 bytes); the single byte-wide output port sets the rate. Input words are
// taken every cycle while the command queue has room. Synchronous reset empties the
// queue and output register and restores max_chunk 255, replacement_char 63, chunk_tag 222.
module beacon_payload_chunk_framer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // payload_byte[7:0], message_length[18:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // frame_byte[7:0]
  output logic        m_tuser,   // run_last
  output logic        m_tlast,   // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  bpcf_pkg::cfg_t cfg;
  bpcf_pkg::cmd_t push_cmd;
  bpcf_pkg::cmd_t head;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           head_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_chunk <= 8'd255;
      cfg.repl_char <= 8'd63;
      cfg.chunk_tag <= 8'd222;
    end else if (cfg_we) begin
      case (cfg_index)
        bpcf_pkg::CFG_MAX_CHUNK: cfg.max_chunk <= cfg_data;
        bpcf_pkg::CFG_REPL_CHAR: cfg.repl_char <= cfg_data;
        bpcf_pkg::CFG_CHUNK_TAG: cfg.chunk_tag <= cfg_data;
        default: ;
      endcase
    end
  end

  bpcf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata[7:0]),
    .in_length (s_tdata[18:8]),
    .q_full    (q_full),
    .in_ready  (s_tready),
    .push      (push),
    .cmd       (push_cmd)
  );

  bpcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  bpcf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_byte      (m_tdata),
    .out_run_last  (m_tuser),
    .out_frame_end (m_tlast)
  );

  `include "beacon_payload_chunk_framer_assert.svh"

  // Frame end only falls on the payload byte that closes a word's run
  `BPCF_ASSERT_IMPLY(a_end_is_run_last, m_tvalid && m_tlast, m_tuser, "frame end without run last")

  // Queue comes out of reset empty, so input is taken right away
  `BPCF_ASSERT_IMPLY(a_ready_after_reset, $past(rst), s_tready && !m_tvalid, "not idle after reset")

  // A full queue never reports an empty head
  `BPCF_ASSERT_ALWAYS(a_full_has_head, !q_full || head_valid, "full queue without head")

endmodule

FILE: sv/bpcf_front.sv
// Front end: tracks message and chunk position and classifies each payload word.
module bpcf_front (
  input  logic                clk,
  input  logic                rst,
  input  bpcf_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic [10:0]         in_length,
  input  logic                q_full,
  output logic                in_ready,
  output logic                push,
  output bpcf_pkg::cmd_t      cmd
);

  logic [10:0] bytes_done, bytes_done_next;
  logic [10:0] held_length, held_length_next;
  logic [7:0]  chunk_fill, chunk_fill_next;

  logic        start;
  logic [10:0] len_eff;
  logic [10:0] done_base;
  logic [7:0]  fill_base;
  logic        open;
  logic [7:0]  cs;
  logic [10:0] left;
  logic [7:0]  clen;
  logic [7:0]  fill_after;
  logic [10:0] done_after;
  logic        last;
  logic        printable;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Classify the incoming word against the running message state
  always_comb begin
    start      = (bytes_done == 11'd0) || (bytes_done >= held_length);
    len_eff    = start ? ((in_length == 11'd0) ? 11'd1 : in_length) : held_length;
    done_base  = start ? 11'd0 : bytes_done;
    fill_base  = start ? 8'd0 : chunk_fill;
    open       = (fill_base == 8'd0);
    cs         = (cfg.max_chunk == 8'd0) ? 8'd1 : cfg.max_chunk;
    left       = len_eff - done_base;
    clen       = (left < {3'b000, cs}) ? left[7:0] : cs;
    fill_after = (open ? clen : fill_base) - 8'd1;
    done_after = done_base + 11'd1;
    last       = (done_after >= len_eff);
    printable  = (in_byte >= bpcf_pkg::PRINT_LO) && (in_byte <= bpcf_pkg::PRINT_HI);

    bytes_done_next  = last ? 11'd0 : done_after;
    chunk_fill_next  = last ? 8'd0 : fill_after;
    held_length_next = len_eff;

    cmd.hdr  = start;
    cmd.open = open;
    cmd.clen = clen;
    cmd.tag  = cfg.chunk_tag;
    cmd.data = printable ? in_byte : cfg.repl_char;
    cmd.last = last;
  end

  // Advance message state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_done  <= 11'd0;
      held_length <= 11'd0;
      chunk_fill  <= 8'd0;
    end else if (push) begin
      bytes_done  <= bytes_done_next;
      held_length <= held_length_next;
      chunk_fill  <= chunk_fill_next;
    end
  end

endmodule

FILE: sv/bpcf_queue.sv
// Short command queue between the classifier and the byte emitter.
module bpcf_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bpcf_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output bpcf_pkg::cmd_t  head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bpcf_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/bpcf_back.sv
// Back end: expands each command into its payload byte, led by header, tag and length bytes as flagged.
module bpcf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  bpcf_pkg::cmd_t  head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_frame_end
);

  localparam int PW = bpcf_pkg::PH_W;
  localparam logic [PW-1:0] PH_HDR_END = PW'(bpcf_pkg::HDR_BYTES - 1);
  localparam logic [PW-1:0] PH_TAG     = PW'(bpcf_pkg::HDR_BYTES);
  localparam logic [PW-1:0] PH_LEN     = PW'(bpcf_pkg::HDR_BYTES + 1);
  localparam logic [PW-1:0] PH_DATA    = PW'(bpcf_pkg::HDR_BYTES + 2);

  bpcf_pkg::cmd_t cur;
  logic           cur_valid;
  logic [PW-1:0]  phase, phase_next;
  logic           slot_free;
  logic           emit;
  logic           at_data;
  logic           load;
  logic [7:0]     byte_sel;

  assign slot_free = !out_valid || out_ready;
  assign emit      = cur_valid && slot_free;
  assign at_data   = (phase == PH_DATA);
  assign load      = !cur_valid || (emit && at_data);
  assign pop       = load && head_valid;

  // Pick the byte for the current phase
  always_comb begin
    if (phase < PH_TAG) begin
      byte_sel = bpcf_pkg::hdr_byte(phase);
    end else if (phase == PH_TAG) begin
      byte_sel = cur.tag;
    end else if (phase == PH_LEN) begin
      byte_sel = cur.clen;
    end else begin
      byte_sel = cur.data;
    end

    if (phase == PH_HDR_END) begin
      phase_next = cur.open ? PH_TAG : PH_DATA;
    end else begin
      phase_next = phase + 1'b1;
    end
  end

  // Hold the current command and step through its phases
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= '0;
    end else if (load) begin
      cur_valid <= head_valid;
      if (head.hdr) begin
        phase <= '0;
      end else begin
        phase <= head.open ? PH_TAG : PH_DATA;
      end
    end else if (emit) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head;
    end
  end

  // Output register: drop on take, fill on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte      <= byte_sel;
      out_run_last  <= at_data;
      out_frame_end <= at_data && cur.last;
    end
  end

endmodule
